@@ hdl/priority_task_queue_macros.svh @@
// ----------------------------------------------------------------------------
// priority_task_queue_macros
// Assertion macros for the priority task queue port checker.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_QUEUE_MACROS_SVH
`define PRIORITY_TASK_QUEUE_MACROS_SVH

// same-cycle implication
`define PTQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ptq_pkg.sv @@
// ----------------------------------------------------------------------------
// ptq_pkg
// Field widths, operation and status codes, control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

    localparam int KIND_W   = 2;
    localparam int TAG_W    = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_PUSH_TAIL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_PRIO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP       = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load_op;
        logic decode;
        logic pop_take;
        logic scan_step;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              empty;
        logic              scan_end;
    } sts_t;

endpackage

`default_nettype wire

@@ hdl/priority_task_queue.sv @@
// ----------------------------------------------------------------------------
// priority_task_queue
// Priority task queue: tail push, priority insert, pop head, clear.
// ----------------------------------------------------------------------------
// One operation is in flight at a time and every beat in gives one beat out.
// Entries live in a circular buffer in a single-port-read, single-port-write
// RAM, so pop moves the head pointer instead of shifting. After accept and
// decode, clear, tail push and rejected operations go straight to result
// load, pop first takes the head entry, and priority push first runs the
// insertion ripple that reads one RAM entry per cycle from the head to the
// tail and rewrites the entries from the insertion point on. The next beat
// is taken in the cycle after the result is loaded into the output
// register, while that result may still be waiting on m_tready.
`default_nettype none

module priority_task_queue #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ptq_pkg::S_DATA_W-1:0]  s_tdata,  // task_tag, priority_req
    input  wire logic [ptq_pkg::KIND_W-1:0]    s_tuser,  // kind
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [ptq_pkg::M_DATA_W-1:0]  m_tdata,  // out_tag, out_priority,
                                                          // count, is_empty, pad
    output logic      [ptq_pkg::STATUS_W-1:0]  m_tuser   // status
);

    ptq_pkg::cmd_t cmd;
    ptq_pkg::sts_t sts;

    ptq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptq_dpath #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

`default_nettype wire

@@ hdl/ptq_ram.sv @@
// ----------------------------------------------------------------------------
// ptq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/ptq_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptq_ctrl
// Operation sequencer: accept, decode, scan or pop where needed, then result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire ptq_pkg::sts_t sts,
    output ptq_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.kind inside {ptq_pkg::KIND_PUSH_TAIL, ptq_pkg::KIND_PUSH_PRIO})
                begin
                    if (sts.full || sts.kind == ptq_pkg::KIND_PUSH_TAIL)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else if (sts.kind == ptq_pkg::KIND_POP && !sts.empty)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = S_RESULT;
                end
            end
            S_POP:
            begin
                cmd.pop_take = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

@@ hdl/ptq_dpath.sv @@
// ----------------------------------------------------------------------------
// ptq_dpath
// Circular queue in RAM with head/occupancy, insertion ripple, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_dpath #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ptq_pkg::cmd_t                 cmd,
    output ptq_pkg::sts_t                      sts,
    input  wire logic [ptq_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic [ptq_pkg::KIND_W-1:0]    s_tuser,
    output logic      [ptq_pkg::M_DATA_W-1:0]  m_tdata,
    output logic      [ptq_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = IDX_W + 1;
    localparam int ENTRY_W = TAG_BITS + PRIO_BITS;
    localparam int PAD_W   = ptq_pkg::M_DATA_W - ptq_pkg::TAG_W - ptq_pkg::PRIO_W
                             - ptq_pkg::COUNT_W - 1;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] ofs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(ofs);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    logic [ptq_pkg::KIND_W-1:0]   kind_reg;
    logic [TAG_BITS-1:0]          tag_reg;
    logic [PRIO_BITS-1:0]         prio_reg;
    logic [TAG_BITS-1:0]          carry_tag_reg;
    logic [PRIO_BITS-1:0]         carry_prio_reg;
    logic [TAG_BITS-1:0]          res_tag_reg;
    logic [PRIO_BITS-1:0]         res_prio_reg;
    logic [ptq_pkg::STATUS_W-1:0] status_reg;
    logic [ptq_pkg::STATUS_W-1:0] status_next;
    logic [ptq_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [ptq_pkg::STATUS_W-1:0] m_tuser_reg;
    logic [IDX_W-1:0]             head_reg;
    logic [CNT_W-1:0]             occ_reg;
    logic [CNT_W-1:0]             idx_reg;
    logic                         found_reg;

    logic                         full;
    logic                         empty;
    logic                         scan_end;
    logic                         hit;
    logic [TAG_BITS-1:0]          rd_tag;
    logic [PRIO_BITS-1:0]         rd_prio;

    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [ENTRY_W-1:0]           mem_wdata;
    logic [IDX_W-1:0]             mem_raddr;
    logic [ENTRY_W-1:0]           mem_rdata;

    ptq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_tag   = mem_rdata[ENTRY_W-1:PRIO_BITS];
    assign rd_prio  = mem_rdata[PRIO_BITS-1:0];
    assign full     = (occ_reg == CNT_W'(DEPTH));
    assign empty    = (occ_reg == '0);
    assign scan_end = (idx_reg == occ_reg);
    assign hit      = found_reg || (rd_prio < prio_reg);

    assign sts.kind     = kind_reg;
    assign sts.full     = full;
    assign sts.empty    = empty;
    assign sts.scan_end = scan_end;

    // insertion ripple: read entry idx+1 while writing the carried entry at idx from the insertion point on
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wrap_idx(head_reg, occ_reg);
        mem_wdata = {tag_reg, prio_reg};
        mem_raddr = head_reg;
        if (cmd.decode && kind_reg == ptq_pkg::KIND_PUSH_TAIL && !full)
        begin
            mem_we = 1'b1;
        end
        if (cmd.scan_step)
        begin
            mem_waddr = wrap_idx(head_reg, idx_reg);
            mem_wdata = {carry_tag_reg, carry_prio_reg};
            mem_raddr = wrap_idx(head_reg, CNT_W'(idx_reg + 1'b1));
            mem_we    = scan_end || hit;
        end
    end

    always_comb
    begin
        status_next = ptq_pkg::ST_DONE;
        case (kind_reg)
            ptq_pkg::KIND_PUSH_TAIL, ptq_pkg::KIND_PUSH_PRIO:
            begin
                if (full)
                begin
                    status_next = ptq_pkg::ST_FULL;
                end
            end
            ptq_pkg::KIND_POP:
            begin
                if (empty)
                begin
                    status_next = ptq_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                status_next = ptq_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            occ_reg   <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.decode)
            begin
                case (kind_reg)
                    ptq_pkg::KIND_CLEAR:
                    begin
                        occ_reg <= '0;
                    end
                    ptq_pkg::KIND_PUSH_TAIL:
                    begin
                        if (!full)
                        begin
                            occ_reg <= occ_reg + 1'b1;
                        end
                    end
                    ptq_pkg::KIND_PUSH_PRIO:
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                    end
                    default:
                    begin
                        found_reg <= found_reg;
                    end
                endcase
            end
            if (cmd.scan_step)
            begin
                if (scan_end)
                begin
                    occ_reg <= occ_reg + 1'b1;
                end
                else
                begin
                    found_reg <= hit;
                    idx_reg   <= idx_reg + 1'b1;
                end
            end
            if (cmd.pop_take)
            begin
                head_reg <= wrap_idx(head_reg, CNT_W'(1));
                occ_reg  <= occ_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            kind_reg <= s_tuser;
            tag_reg  <= TAG_BITS'(s_tdata[ptq_pkg::TAG_W-1:0]);
            prio_reg <= PRIO_BITS'(s_tdata[ptq_pkg::S_DATA_W-1:ptq_pkg::TAG_W]);
        end
        if (cmd.decode)
        begin
            status_reg     <= status_next;
            res_tag_reg    <= '0;
            res_prio_reg   <= '0;
            carry_tag_reg  <= tag_reg;
            carry_prio_reg <= prio_reg;
        end
        if (cmd.scan_step && !scan_end && hit)
        begin
            carry_tag_reg  <= rd_tag;
            carry_prio_reg <= rd_prio;
        end
        if (cmd.pop_take)
        begin
            res_tag_reg  <= rd_tag;
            res_prio_reg <= rd_prio;
        end
        if (cmd.load_result)
        begin
            m_tdata_reg <= {PAD_W'(0),
                            empty,
                            ptq_pkg::COUNT_W'(occ_reg),
                            ptq_pkg::PRIO_W'(res_prio_reg),
                            ptq_pkg::TAG_W'(res_tag_reg)};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

`default_nettype wire

@@ hdl/ptq_checker.sv @@
// ----------------------------------------------------------------------------
// ptq_checker
// Port-level checks for the priority task queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_task_queue_macros.svh"

module ptq_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ptq_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic [ptq_pkg::STATUS_W-1:0]  m_tuser
);

    `PTQ_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

    `PTQ_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready, "second beat taken while an operation is in flight")

    `PTQ_ASSERT_NOW(a_fail_no_payload, clk, rst_n, m_tvalid && m_tuser != ptq_pkg::ST_DONE, m_tdata[23:0] == 24'd0, "failed operation returned tag or priority")

    `PTQ_ASSERT_NOW(a_pop_empty_flag, clk, rst_n, m_tvalid && m_tuser == ptq_pkg::ST_EMPTY, m_tdata[29], "pop on empty queue without empty flag")

endmodule

bind priority_task_queue ptq_checker u_ptq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ verif/priority_task_queue_checker.sv @@
// ----------------------------------------------------------------------------
// priority_task_queue_checker
// Watches both stream channels of the priority task queue, keeps a mirror
// of the ordered queue, predicts the outcome of every accepted operation and
// compares each result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module priority_task_queue_checker #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [ptq_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [ptq_pkg::KIND_W-1:0]   s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [ptq_pkg::M_DATA_W-1:0] m_tdata,
    input  logic [ptq_pkg::STATUS_W-1:0] m_tuser,
    output int                           mismatches,
    output int                           outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ptq_pkg::STATUS_W-1:0] status;
        logic [ptq_pkg::TAG_W-1:0]    tag;
        logic [ptq_pkg::PRIO_W-1:0]   prio;
        logic [ptq_pkg::COUNT_W-1:0]  count;
        logic                         is_empty;
    } outcome_t;

    logic [ptq_pkg::TAG_W-1:0]  held_tag  [DEPTH];
    logic [ptq_pkg::PRIO_W-1:0] held_prio [DEPTH];
    int                         held_count;
    outcome_t                   expected_outcomes [$];

    function automatic outcome_t apply_op(input logic [ptq_pkg::KIND_W-1:0] kind,
                                          input logic [ptq_pkg::TAG_W-1:0]  tag,
                                          input logic [ptq_pkg::PRIO_W-1:0] prio);
        outcome_t res;
        int       pos;
        res = '0;
        res.status = ptq_pkg::ST_DONE;
        if (kind == ptq_pkg::KIND_PUSH_TAIL || kind == ptq_pkg::KIND_PUSH_PRIO)
        begin
            if (held_count >= DEPTH)
                res.status = ptq_pkg::ST_FULL;
            else
            begin
                pos = held_count;
                if (kind == ptq_pkg::KIND_PUSH_PRIO)
                begin
                    for (int i = 0; i < held_count; i++)
                    begin
                        if (held_prio[i] < prio)
                        begin
                            pos = i;
                            break;
                        end
                    end
                end
                for (int i = held_count; i > pos; i--)
                begin
                    held_tag[i]  = held_tag[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_tag[pos]  = tag;
                held_prio[pos] = prio;
                held_count++;
            end
        end
        else if (kind == ptq_pkg::KIND_POP)
        begin
            if (held_count == 0)
                res.status = ptq_pkg::ST_EMPTY;
            else
            begin
                res.tag  = held_tag[0];
                res.prio = held_prio[0];
                for (int i = 1; i < held_count; i++)
                begin
                    held_tag[i-1]  = held_tag[i];
                    held_prio[i-1] = held_prio[i];
                end
                held_count--;
            end
        end
        else
            held_count = 0;
        res.count    = ptq_pkg::COUNT_W'(held_count);
        res.is_empty = (held_count == 0);
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                          input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            held_count = 0;
            expected_outcomes.delete();
            outstanding = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_outcomes.push_back(apply_op(s_tuser,
                                                     s_tdata[ptq_pkg::TAG_W-1:0],
                                                     s_tdata[ptq_pkg::TAG_W +: ptq_pkg::PRIO_W]));
            if (m_tvalid && m_tready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result beat with no operation pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    compare_field("status", 32'(want.status), 32'(m_tuser));
                    compare_field("out_tag", 32'(want.tag),
                                  32'(m_tdata[ptq_pkg::TAG_W-1:0]));
                    compare_field("out_priority", 32'(want.prio),
                                  32'(m_tdata[ptq_pkg::TAG_W +: ptq_pkg::PRIO_W]));
                    compare_field("count", 32'(want.count),
                                  32'(m_tdata[ptq_pkg::TAG_W+ptq_pkg::PRIO_W +:
                                              ptq_pkg::COUNT_W]));
                    compare_field("is_empty", 32'(want.is_empty),
                                  32'(m_tdata[ptq_pkg::TAG_W+ptq_pkg::PRIO_W+
                                              ptq_pkg::COUNT_W]));
                end
            end
            outstanding = expected_outcomes.size();
        end
    end

endmodule

@@ verif/priority_task_queue_tb.sv @@
// ----------------------------------------------------------------------------
// priority_task_queue_tb
// Drives tail pushes, priority inserts, pops and clears into the priority
// task queue: a directed pass over empty, full, tie and extreme-value cases,
// then random phases that fill, drain or balance the queue, with random gaps on
// both channels and one long output stall. Checking lives in the checker.
// ----------------------------------------------------------------------------
module priority_task_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int RAND_OPS    = 1300;
    localparam int PHASE_OPS   = 100;
    localparam int DRAIN_WAIT  = 60;
    localparam int LONG_HOLD   = 300;

    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [ptq_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [ptq_pkg::KIND_W-1:0]   s_tuser  = ptq_pkg::KIND_PUSH_TAIL;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [ptq_pkg::M_DATA_W-1:0] m_tdata;
    logic [ptq_pkg::STATUS_W-1:0] m_tuser;

    int mismatches;
    int outstanding;
    int tx_gap_max   = 12;
    int rx_stall_max = 12;
    int hold_cycles  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    priority_task_queue #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (ptq_pkg::PRIO_W),
        .TAG_BITS  (ptq_pkg::TAG_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    priority_task_queue_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_op(input logic [ptq_pkg::KIND_W-1:0] kind,
                           input logic [ptq_pkg::TAG_W-1:0]  tag,
                           input logic [ptq_pkg::PRIO_W-1:0] prio);
        int gap;
        gap = $urandom_range(tx_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {prio, tag};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = $urandom_range(rx_stall_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        int                         push_pct;
        int                         pick;
        logic [ptq_pkg::KIND_W-1:0] kind;
        logic [ptq_pkg::PRIO_W-1:0] prio;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: clear and pop
        send_op(ptq_pkg::KIND_CLEAR, 16'hFFFF, 8'hFF);
        send_op(ptq_pkg::KIND_POP, 16'hA5A5, 8'h5A);
        // fill to the brim with extremes and priority ties
        send_op(ptq_pkg::KIND_PUSH_TAIL, 16'h0000, 8'h00);
        send_op(ptq_pkg::KIND_PUSH_TAIL, 16'hFFFF, 8'hFF);
        send_op(ptq_pkg::KIND_PUSH_PRIO, 16'h1111, 8'hFF);
        send_op(ptq_pkg::KIND_PUSH_PRIO, 16'h2222, 8'h00);
        send_op(ptq_pkg::KIND_PUSH_PRIO, 16'h3333, 8'h80);
        send_op(ptq_pkg::KIND_PUSH_PRIO, 16'h4444, 8'h80);
        send_op(ptq_pkg::KIND_PUSH_PRIO, 16'h5555, 8'h81);
        send_op(ptq_pkg::KIND_PUSH_TAIL, 16'h6666, 8'h7F);
        for (int i = 0; i < DEPTH - 8; i++)
            send_op($urandom_range(1) ? ptq_pkg::KIND_PUSH_PRIO : ptq_pkg::KIND_PUSH_TAIL,
                    ptq_pkg::TAG_W'($urandom), ptq_pkg::PRIO_W'($urandom_range(3)));
        // full queue: both push kinds rejected
        send_op(ptq_pkg::KIND_PUSH_TAIL, 16'hBEEF, 8'h01);
        send_op(ptq_pkg::KIND_PUSH_PRIO, 16'hCAFE, 8'hFF);
        send_op(ptq_pkg::KIND_POP, 16'h0000, 8'h00);
        send_op(ptq_pkg::KIND_POP, 16'hFFFF, 8'hFF);
        send_op(ptq_pkg::KIND_CLEAR, 16'h0000, 8'h00);
        send_op(ptq_pkg::KIND_POP, 16'h0000, 8'h00);

        for (int n = 0; n < RAND_OPS; n++)
        begin
            if (n % PHASE_OPS == 0)
            begin
                case ($urandom_range(2))
                    0: push_pct = 75;
                    1: push_pct = 25;
                    default: push_pct = 50;
                endcase
                case ($urandom_range(2))
                    0: tx_gap_max = 0;
                    1: tx_gap_max = 3;
                    default: tx_gap_max = 12;
                endcase
                case ($urandom_range(2))
                    0: rx_stall_max = 0;
                    1: rx_stall_max = 3;
                    default: rx_stall_max = 12;
                endcase
            end
            if (n == RAND_OPS / 3)
                hold_cycles = LONG_HOLD;
            pick = $urandom_range(99);
            if (pick < 2)
                kind = ptq_pkg::KIND_CLEAR;
            else if (pick < 2 + push_pct)
                kind = $urandom_range(1) ? ptq_pkg::KIND_PUSH_PRIO : ptq_pkg::KIND_PUSH_TAIL;
            else
                kind = ptq_pkg::KIND_POP;
            // narrow priorities make ties common
            if ($urandom_range(1))
                prio = ptq_pkg::PRIO_W'($urandom_range(3));
            else
                prio = ptq_pkg::PRIO_W'($urandom_range(255));
            send_op(kind, ptq_pkg::TAG_W'($urandom), prio);
        end
        s_tvalid <= 1'b0;

        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("[priority_task_queue] OK");
        else
            $display("[priority_task_queue] ERROR");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("[priority_task_queue] ERROR");
        $finish;
    end

endmodule
